>>> sv/spdlp_pkg.sv
// ----------------------------------------------------------------------------
// spdlp_pkg
// Shared types, codes and the per-character parse step of the SPI device
// line parser.
// ----------------------------------------------------------------------------
package spdlp_pkg;

    localparam int MAX_NAME_DEFAULT = 32;
    localparam logic [5:0] NAME_LIMIT_RESET = 6'd32;

    // Output queue geometry
    localparam int OQ_DEPTH = 4;
    localparam int OQ_AW    = 2;
    localparam int OQ_CW    = 3;

    // Parser phases
    localparam logic [3:0] PH_S     = 4'd0;
    localparam logic [3:0] PH_P     = 4'd1;
    localparam logic [3:0] PH_I     = 4'd2;
    localparam logic [3:0] PH_PORT  = 4'd3;
    localparam logic [3:0] PH_COMMA = 4'd4;
    localparam logic [3:0] PH_NAME  = 4'd5;
    localparam logic [3:0] PH_ADDR  = 4'd6;
    localparam logic [3:0] PH_CHAN  = 4'd7;
    localparam logic [3:0] PH_SPEED = 4'd8;
    localparam logic [3:0] PH_PIX   = 4'd9;

    // Status codes
    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_PROTO = 3'd1;
    localparam logic [2:0] ST_DEV   = 3'd2;
    localparam logic [2:0] ST_SLAVE = 3'd3;
    localparam logic [2:0] ST_START = 3'd4;
    localparam logic [2:0] ST_SPEED = 3'd5;
    localparam logic [2:0] ST_PIX   = 3'd6;

    localparam logic [2:0] FC_BASE  = 3'd5;
    localparam logic [2:0] FC_PIX   = 3'd6;

    // Characters
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_I     = 8'h49;
    localparam logic [7:0] PIX_MAX  = 8'hFF;

    typedef struct packed {
        logic [3:0]  phase;
        logic [3:0]  digit_count;
        logic [29:0] acc;
        logic [5:0]  name_count;
        logic [3:0]  port_hold;
        logic [7:0]  address_hold;
        logic [9:0]  channel_hold;
        logic [29:0] speed_hold;
        logic        skip;
    } parse_state_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  pixel_count;
        logic [29:0] speed_hz;
        logic [9:0]  start_channel;
        logic [7:0]  slave_address;
        logic [5:0]  name_length;
        logic [3:0]  spi_port;
        logic [2:0]  field_count;
        logic [2:0]  status;
        logic [7:0]  name_char;
    } rec_t;

    typedef struct packed {
        parse_state_t st;
        logic         vld;
        rec_t         rec;
    } step_t;

    typedef struct packed {
        logic             space;
        logic [OQ_CW-1:0] level;
    } oq_status_t;

    function automatic step_t spdlp_feed(parse_state_t st, logic [7:0] c, logic [7:0] lim);
        step_t       f;
        logic        dec;
        logic        hex;
        logic [7:0]  lc;
        logic [3:0]  hexval;
        logic [29:0] acc10;
        logic [29:0] acc16;
        logic        fin;
        logic [2:0]  stat;
        logic [2:0]  cnt;
        logic [7:0]  pix;
        logic        term;
        f      = '0;
        f.st   = st;
        dec    = (c >= 8'h30) && (c <= 8'h39);
        lc     = c | CH_SPACE;
        hex    = dec || ((lc >= 8'h61) && (lc <= 8'h66));
        hexval = dec ? c[3:0] : (lc[3:0] + 4'd9);
        acc10  = {st.acc[26:0], 3'b000} + {st.acc[28:0], 1'b0} + {26'd0, c[3:0]};
        acc16  = {st.acc[25:0], hexval};
        fin    = 1'b0;
        stat   = ST_OK;
        cnt    = 3'd0;
        pix    = 8'd0;
        term   = (c == CH_NUL) || (c == CH_LF) || (c == CH_SPACE);
        if (!st.skip) begin
            case (st.phase)
                PH_S, PH_P, PH_I: begin
                    if ((st.phase == PH_S && c == CH_S) || (st.phase == PH_P && c == CH_P) ||
                        (st.phase == PH_I && c == CH_I)) begin
                        f.st.phase = st.phase + 4'd1;
                    end else begin
                        fin  = 1'b1;
                        stat = ST_PROTO;
                    end
                end
                PH_PORT: begin
                    if (dec) begin
                        f.st.port_hold = c[3:0];
                        f.st.phase     = PH_COMMA;
                    end else begin
                        fin  = 1'b1;
                        stat = ST_PROTO;
                    end
                end
                PH_COMMA: begin
                    if (c == CH_COMMA) begin
                        f.st.phase = PH_NAME;
                    end else begin
                        fin  = 1'b1;
                        stat = ST_PROTO;
                    end
                end
                PH_NAME: begin
                    if (c == CH_COMMA) begin
                        f.st.phase       = PH_ADDR;
                        f.st.digit_count = 4'd0;
                        f.st.acc         = 30'd0;
                    end else if (c != CH_NUL && {2'b00, st.name_count} < lim) begin
                        f.vld           = 1'b1;
                        f.rec.name_char = (c >= 8'h41 && c <= 8'h5A) ? (c | CH_SPACE) : c;
                        f.st.name_count = st.name_count + 6'd1;
                    end else begin
                        fin  = 1'b1;
                        stat = ST_DEV;
                    end
                end
                PH_ADDR: begin
                    if (c == CH_COMMA && st.digit_count != 4'd0) begin
                        f.st.address_hold = st.acc[7:0];
                        f.st.phase        = PH_CHAN;
                        f.st.digit_count  = 4'd0;
                        f.st.acc          = 30'd0;
                    end else if (hex && st.digit_count < 4'd2) begin
                        f.st.acc         = acc16;
                        f.st.digit_count = st.digit_count + 4'd1;
                    end else begin
                        fin  = 1'b1;
                        stat = ST_SLAVE;
                    end
                end
                PH_CHAN: begin
                    if (c == CH_COMMA && st.digit_count != 4'd0) begin
                        f.st.channel_hold = st.acc[9:0];
                        f.st.phase        = PH_SPEED;
                        f.st.digit_count  = 4'd0;
                        f.st.acc          = 30'd0;
                    end else if (dec && st.digit_count < 4'd3) begin
                        f.st.acc         = acc10;
                        f.st.digit_count = st.digit_count + 4'd1;
                    end else begin
                        fin  = 1'b1;
                        stat = ST_START;
                    end
                end
                PH_SPEED: begin
                    if (term || c == CH_COLON) begin
                        if (st.digit_count == 4'd0) begin
                            fin  = 1'b1;
                            stat = ST_SPEED;
                        end else begin
                            f.st.speed_hold = st.acc;
                            if (c == CH_COLON) begin
                                f.st.phase       = PH_PIX;
                                f.st.digit_count = 4'd0;
                                f.st.acc         = 30'd0;
                            end else begin
                                fin = 1'b1;
                                cnt = FC_BASE;
                            end
                        end
                    end else if (dec && st.digit_count < 4'd9) begin
                        f.st.acc         = acc10;
                        f.st.digit_count = st.digit_count + 4'd1;
                    end else begin
                        fin  = 1'b1;
                        stat = ST_SPEED;
                    end
                end
                default: begin
                    // pixel field
                    if (term) begin
                        fin = 1'b1;
                        if (st.digit_count == 4'd0 || st.acc > {22'd0, PIX_MAX}) begin
                            stat = ST_PIX;
                        end else begin
                            cnt = FC_PIX;
                            pix = st.acc[7:0];
                        end
                    end else if (dec && st.digit_count < 4'd3) begin
                        f.st.acc         = acc10;
                        f.st.digit_count = st.digit_count + 4'd1;
                    end else begin
                        fin  = 1'b1;
                        stat = ST_PIX;
                    end
                end
            endcase
        end
        if (fin) begin
            f.vld        = 1'b1;
            f.rec        = '0;
            f.rec.kind   = 1'b1;
            f.rec.status = stat;
            if (stat == ST_OK) begin
                f.rec.field_count   = cnt;
                f.rec.spi_port      = f.st.port_hold;
                f.rec.name_length   = f.st.name_count;
                f.rec.slave_address = f.st.address_hold;
                f.rec.start_channel = f.st.channel_hold;
                f.rec.speed_hz      = f.st.speed_hold;
                f.rec.pixel_count   = pix;
            end
            f.st.skip = 1'b1;
        end
        // end of line: start over
        if (c == CH_NUL) begin
            f.st = '0;
        end
        return f;
    endfunction

endpackage

>>> sv/spdlp_out_queue.sv
// ----------------------------------------------------------------------------
// spdlp_out_queue
// Small result queue: up to two records in per cycle, one out when out_ready.
// ----------------------------------------------------------------------------
module spdlp_out_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push0,
    input  logic                  push1,
    input  spdlp_pkg::rec_t       data0,
    input  spdlp_pkg::rec_t       data1,
    output spdlp_pkg::oq_status_t stat,
    output logic                  out_valid,
    input  logic                  out_ready,
    output spdlp_pkg::rec_t       out_data
);

    spdlp_pkg::rec_t                 mem [spdlp_pkg::OQ_DEPTH];
    logic [spdlp_pkg::OQ_AW-1:0]     wr_ptr_reg;
    logic [spdlp_pkg::OQ_AW-1:0]     wr_ptr_next;
    logic [spdlp_pkg::OQ_AW-1:0]     rd_ptr_reg;
    logic [spdlp_pkg::OQ_AW-1:0]     rd_ptr_next;
    logic [spdlp_pkg::OQ_CW-1:0]     count_reg;
    logic [spdlp_pkg::OQ_CW-1:0]     count_next;
    logic                            pop;

    assign pop       = out_valid && out_ready;
    assign out_valid = (count_reg != '0);
    assign out_data  = mem[rd_ptr_reg];

    assign stat.space = (count_reg <= spdlp_pkg::OQ_CW'(spdlp_pkg::OQ_DEPTH - 2));
    assign stat.level = count_reg;

    always_comb begin
        wr_ptr_next = wr_ptr_reg + spdlp_pkg::OQ_AW'(push0) + spdlp_pkg::OQ_AW'(push1);
        rd_ptr_next = rd_ptr_reg + spdlp_pkg::OQ_AW'(pop);
        count_next  = count_reg + spdlp_pkg::OQ_CW'(push0) + spdlp_pkg::OQ_CW'(push1)
                      - spdlp_pkg::OQ_CW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push0) begin
            mem[wr_ptr_reg] <= data0;
        end
        if (push1) begin
            mem[wr_ptr_reg + spdlp_pkg::OQ_AW'(1)] <= data1;
        end
    end

endmodule

>>> sv/spi_device_line_parser.sv
// ----------------------------------------------------------------------------
// spi_device_line_parser
// Character-at-a-time parser for "SPIn,name,hh,ddd,speed[:pixels]" lines.
// ----------------------------------------------------------------------------
// One character arrives per s_axis transfer (tdata = ch, tlast = end of
// buffer; a zero character also ends the line). Each lowercased name
// character leaves as an m_axis transfer with tlast low; every line ends in
// one transfer with tlast high carrying a status or the field count and the
// converted fields. A character can give up to two results, for example a
// name character followed by the error raised by the implied line end.
// The character is registered, parsed combinationally into a four-entry
// result queue, and shown on m_axis from that queue's registers.
// A character is taken every cycle while the queue has room for two
// records; the queue drains one record per cycle while m_axis_tready is
// high, so lines of many name characters then run at one result per cycle.
// When the receiver stalls, results wait in the queue and s_axis_tready
// drops while a character waits in the input register and the queue has
// fewer than two free entries; nothing is lost.
// Reset empties the queue, returns the parser to a line start and sets the
// name limit to 32. Users write it by cfg_we only while idle (not enforced).
// ----------------------------------------------------------------------------
module spi_device_line_parser #(
    parameter int MAX_NAME = spdlp_pkg::MAX_NAME_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [5:0]  cfg_wdata,      // name_limit
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // ch
    input  logic        s_axis_tlast,   // last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // name_char, status, field_count, spi_port, name_length, slave_address,
    // start_channel, speed_hz, pixel_count
    output logic [79:0] m_axis_tdata,
    output logic        m_axis_tlast    // kind
);

    logic [5:0]              name_limit_reg;
    logic                    in_valid_reg;
    logic [7:0]              ch_reg;
    logic                    last_reg;
    spdlp_pkg::parse_state_t st_reg;
    spdlp_pkg::parse_state_t st_next;
    spdlp_pkg::step_t        f1;
    spdlp_pkg::step_t        f2;
    spdlp_pkg::oq_status_t   oq_stat;
    spdlp_pkg::rec_t         rec0;
    spdlp_pkg::rec_t         out_rec;
    logic [7:0]              lim;
    logic                    use_second;
    logic                    process;
    logic                    push0;
    logic                    push1;

    assign lim = ({2'b00, name_limit_reg} < 8'(MAX_NAME)) ? {2'b00, name_limit_reg}
                                                         : 8'(MAX_NAME);

    assign process       = in_valid_reg && oq_stat.space;
    assign s_axis_tready = !in_valid_reg || process;

    always_comb begin
        f1         = spdlp_pkg::spdlp_feed(st_reg, ch_reg, lim);
        // buffer end: the line closes as if a zero followed
        f2         = spdlp_pkg::spdlp_feed(f1.st, spdlp_pkg::CH_NUL, lim);
        use_second = last_reg && (ch_reg != spdlp_pkg::CH_NUL);
        st_next    = use_second ? f2.st : f1.st;
        rec0       = f1.vld ? f1.rec : f2.rec;
        push0      = process && (f1.vld || (use_second && f2.vld));
        push1      = process && f1.vld && use_second && f2.vld;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            name_limit_reg <= spdlp_pkg::NAME_LIMIT_RESET;
            in_valid_reg   <= 1'b0;
            st_reg         <= '0;
        end else begin
            if (cfg_we) begin
                name_limit_reg <= cfg_wdata;
            end
            if (s_axis_tready) begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (process) begin
                st_reg <= st_next;
            end
        end
    end

    // hold the character until it is parsed
    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            ch_reg   <= s_axis_tdata;
            last_reg <= s_axis_tlast;
        end
    end

    spdlp_out_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push0     (push0),
        .push1     (push1),
        .data0     (rec0),
        .data1     (f2.rec),
        .stat      (oq_stat),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (out_rec)
    );

    assign m_axis_tlast = out_rec.kind;
    assign m_axis_tdata = {out_rec.pixel_count, out_rec.speed_hz, out_rec.start_channel,
                           out_rec.slave_address, out_rec.name_length, out_rec.spi_port,
                           out_rec.field_count, out_rec.status, out_rec.name_char};

    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        oq_stat.level <= spdlp_pkg::OQ_CW'(spdlp_pkg::OQ_DEPTH))
        else $error("result queue overflow");

    a_pair_needs_end: assert property (@(posedge aclk) disable iff (!aresetn)
        push1 |-> (last_reg && ch_reg != spdlp_pkg::CH_NUL && push0))
        else $error("two results without a buffer end");

    a_name_rec_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tlast) |-> (m_axis_tdata[79:8] == '0))
        else $error("name record carries field data");

    a_digit_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg.digit_count <= 4'd9 && st_reg.phase <= spdlp_pkg::PH_PIX)
        else $error("parser state out of range");

endmodule
